/* sv/rounded_rect_coverage_blend_assert.svh */
// ----------------------------------------------------------------------------
// Rounded-rect coverage blend assertion macros
// Shared property shapes for the blend pipeline and its queues.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_COVERAGE_BLEND_ASSERT_SVH
`define ROUNDED_RECT_COVERAGE_BLEND_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define RRCB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrcb same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst
`define RRCB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrcb next-cycle check failed");

`endif

/* sv/rrcb_pkg.sv */
// ----------------------------------------------------------------------------
// rrcb_pkg
// Shared constants and types for the rounded-rect coverage blend unit.
// ----------------------------------------------------------------------------
package rrcb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int QUEUE_DEPTH    = 2;

  // Register index codes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCISSOR_LEFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCISSOR_TOP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCISSOR_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCISSOR_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT  = 3'd5;

  // Classification flags handed from front to back
  typedef struct packed {
    logic clip_ok;
    logic in_rect;
    logic corner_hit;
  } geom_t;

endpackage

/* sv/rrcb_queue.sv */
// ----------------------------------------------------------------------------
// rrcb_queue
// Small first-word-fall-through queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`include "rounded_rect_coverage_blend_assert.svh"

module rrcb_queue import rrcb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign push_fire = push && !full;
  assign pop_fire  = pop && !empty;
  assign rdata     = mem[rd_ptr];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  `RRCB_ASSERT_NEXT(a_push_not_empty, push_fire && !pop_fire, !empty)
  `RRCB_ASSERT_NEXT(a_last_pop_empty, pop_fire && !push_fire && count == CNT_W'(1), empty)
  `RRCB_ASSERT_IMP(a_full_not_empty, full, !empty)

endmodule

/* sv/rrcb_front.sv */
// ----------------------------------------------------------------------------
// rrcb_front
// Holds the clip registers and classifies each pixel: scissor/screen test,
// rectangle test, corner selection and corner-centre offsets.
// ----------------------------------------------------------------------------
module rrcb_front import rrcb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_BITS:0]        cfg_data,
  input  logic [COORD_BITS-1:0]      pixel_x,
  input  logic [COORD_BITS-1:0]      pixel_y,
  input  logic signed [COORD_BITS:0] rect_left,
  input  logic signed [COORD_BITS:0] rect_top,
  input  logic [COORD_BITS:0]        rect_width,
  input  logic [COORD_BITS:0]        rect_height,
  input  logic [FRAC_BITS+7:0]       radius_top_left,
  input  logic [FRAC_BITS+7:0]       radius_top_right,
  input  logic [FRAC_BITS+7:0]       radius_bottom_right,
  input  logic [FRAC_BITS+7:0]       radius_bottom_left,
  output geom_t                      geom,
  output logic signed [FRAC_BITS+9:0] dx,
  output logic signed [FRAC_BITS+9:0] dy,
  output logic [FRAC_BITS+7:0]       radius
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int IW = C + 3;
  localparam int W  = IW + F + 1;
  localparam int SD = F + 10;
  localparam int RW = F + 8;
  localparam logic signed [W-1:0] HALF_FX = W'(1) <<< (F - 1);

  logic [C-1:0] scissor_left;
  logic [C-1:0] scissor_top;
  logic [C:0]   scissor_width;
  logic [C:0]   scissor_height;
  logic [C:0]   screen_width;
  logic [C:0]   screen_height;

  logic signed [IW-1:0] px_i, py_i, rx_i, ry_i, rr_i, rb_i;
  logic signed [W-1:0]  pxs, pys, pxf, pyf, lf, tf, rf, bf;
  logic signed [W-1:0]  r0, r1, r2, r3, dx_w, dy_w;
  logic                 hit_tl, hit_tr, hit_bl, hit_br;
  logic [C+1:0]         sx_end, sy_end;

  // Write clip registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scissor_left   <= '0;
      scissor_top    <= '0;
      scissor_width  <= (C+1)'(1) << C;
      scissor_height <= (C+1)'(1) << C;
      screen_width   <= (C+1)'(1) << C;
      screen_height  <= (C+1)'(1) << C;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCISSOR_LEFT:   scissor_left   <= cfg_data[C-1:0];
        REG_SCISSOR_TOP:    scissor_top    <= cfg_data[C-1:0];
        REG_SCISSOR_WIDTH:  scissor_width  <= cfg_data;
        REG_SCISSOR_HEIGHT: scissor_height <= cfg_data;
        REG_SCREEN_WIDTH:   screen_width   <= cfg_data;
        REG_SCREEN_HEIGHT:  screen_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Integer coordinates and rectangle bounds
  assign px_i = $signed({{(IW-C){1'b0}}, pixel_x});
  assign py_i = $signed({{(IW-C){1'b0}}, pixel_y});
  assign rx_i = $signed({{(IW-C-1){rect_left[C]}}, rect_left});
  assign ry_i = $signed({{(IW-C-1){rect_top[C]}}, rect_top});
  assign rr_i = rx_i + $signed({{(IW-C-1){1'b0}}, rect_width});
  assign rb_i = ry_i + $signed({{(IW-C-1){1'b0}}, rect_height});

  // Fixed-point positions
  assign pxs = $signed({px_i[IW-1], px_i, {F{1'b0}}});
  assign pys = $signed({py_i[IW-1], py_i, {F{1'b0}}});
  assign lf  = $signed({rx_i[IW-1], rx_i, {F{1'b0}}});
  assign tf  = $signed({ry_i[IW-1], ry_i, {F{1'b0}}});
  assign rf  = $signed({rr_i[IW-1], rr_i, {F{1'b0}}});
  assign bf  = $signed({rb_i[IW-1], rb_i, {F{1'b0}}});
  assign pxf = pxs + HALF_FX;
  assign pyf = pys + HALF_FX;
  assign r0  = $signed({{(W-RW){1'b0}}, radius_top_left});
  assign r1  = $signed({{(W-RW){1'b0}}, radius_top_right});
  assign r2  = $signed({{(W-RW){1'b0}}, radius_bottom_right});
  assign r3  = $signed({{(W-RW){1'b0}}, radius_bottom_left});

  // Corner squares
  assign hit_tl = (pxs < lf + r0) && (pys < tf + r0);
  assign hit_tr = (pxs >= rf - r1) && (pys < tf + r1);
  assign hit_bl = (pxs < lf + r3) && (pys >= bf - r3);
  assign hit_br = (pxs >= rf - r2) && (pys >= bf - r2);

  // Pick the first corner in order and form offsets to its centre
  always_comb begin
    dx_w   = '0;
    dy_w   = '0;
    radius = '0;
    if (hit_tl) begin
      radius = radius_top_left;
      dx_w   = lf + r0 - pxf;
      dy_w   = tf + r0 - pyf;
    end else if (hit_tr) begin
      radius = radius_top_right;
      dx_w   = pxf - (rf - r1);
      dy_w   = tf + r1 - pyf;
    end else if (hit_bl) begin
      radius = radius_bottom_left;
      dx_w   = lf + r3 - pxf;
      dy_w   = pyf - (bf - r3);
    end else if (hit_br) begin
      radius = radius_bottom_right;
      dx_w   = pxf - (rf - r2);
      dy_w   = pyf - (bf - r2);
    end
  end

  assign dx = dx_w[SD-1:0];
  assign dy = dy_w[SD-1:0];

  // Scissor and screen test
  assign sx_end = {2'b00, scissor_left} + {1'b0, scissor_width};
  assign sy_end = {2'b00, scissor_top} + {1'b0, scissor_height};

  always_comb begin
    geom.in_rect    = (px_i >= rx_i) && (px_i < rr_i) && (py_i >= ry_i) && (py_i < rb_i);
    geom.corner_hit = hit_tl || hit_tr || hit_bl || hit_br;
    geom.clip_ok    = (pixel_x >= scissor_left) && ({2'b00, pixel_x} < sx_end) &&
                      (pixel_y >= scissor_top) && ({2'b00, pixel_y} < sy_end) &&
                      ({1'b0, pixel_x} < screen_width) && ({1'b0, pixel_y} < screen_height);
  end

endmodule

/* sv/rrcb_back.sv */
// ----------------------------------------------------------------------------
// rrcb_back
// Pipelined coverage and blend: squared distance, one-bit-per-stage square
// root, smoothstep edge, alpha scaling and the divide-by-255 blend.
// ----------------------------------------------------------------------------
`include "rounded_rect_coverage_blend_assert.svh"

module rrcb_back import rrcb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_pop,
  input  geom_t                       in_geom,
  input  logic signed [FRAC_BITS+9:0] in_dx,
  input  logic signed [FRAC_BITS+9:0] in_dy,
  input  logic [FRAC_BITS+7:0]        in_radius,
  input  logic [31:0]                 in_src,
  input  logic [31:0]                 in_dst,
  input  logic                        out_full,
  output logic                        out_push,
  output logic                        out_we,
  output logic [31:0]                 out_rgba,
  output logic [8:0]                  out_cov
);

  localparam int F     = FRAC_BITS;
  localparam int SD    = F + 10;
  localparam int RW    = F + 8;
  localparam int SQ    = 2 * SD - 2;
  localparam int R     = F + 18;
  localparam int NW    = 2 * R;
  localparam int EW    = F + 21;
  localparam int VW    = F + 9;
  localparam int MB    = F + 7;
  localparam int WW    = F + 11;
  localparam int V2W   = 2 * VW;
  localparam int PW    = V2W + WW;
  localparam int K     = 3 * MB;
  localparam int YW    = 13;
  localparam int NST   = R + 8;
  localparam int ST_E  = R + 2;
  localparam int ST_D  = R + 5;
  localparam int ST_A  = R + 6;
  localparam logic signed [EW-1:0] EDGE_T = EW'(3) <<< (F + 6);
  localparam logic [WW-1:0]        NINE_M = WW'(9) << MB;
  localparam logic [PW:0]          ROUND_C = (PW+1)'(27) << (K - 9);
  localparam logic [15:0]          RECIP_27 = 16'd38837;

  localparam logic [1:0] KIND_MID  = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_ZERO = 2'd2;

  typedef struct packed {
    geom_t          geom;
    logic [RW-1:0]  radius;
    logic [31:0]    src;
    logic [31:0]    dst;
  } side_t;

  // Exact floor(t/255) for t up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] t);
    logic [16:0] s;
    s = {1'b0, t} + 17'(t[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  logic [NST-1:0] vld;
  side_t          side [NST];
  side_t          in_side;
  logic           adv;

  logic signed [2*SD-1:0] dxx, dyy;
  logic [SQ-1:0]          dx2, dy2;
  logic [NW-1:0]          rem_q  [R];
  logic [R-1:0]           root_q [R+1];

  logic signed [EW-1:0]   e_w;
  logic [1:0]             kind_e, kind_m1, kind_m2;
  logic [VW-1:0]          v_e;
  logic [V2W-1:0]         v2_m1;
  logic [WW-1:0]          w_m1;
  logic [PW-1:0]          p_m2;
  logic [PW:0]            ysum;
  logic [YW+15:0]         yprod;
  logic [8:0]             cov_d, cov_a, cov_b;
  logic [16:0]            aprod;
  logic [7:0]             a_w, a_q;
  logic                   we_a, we_b, full_b;
  logic [15:0]            t_b [3];
  logic [7:0]             da_b;
  logic [8:0]             da_sum;

  assign in_side = '{geom: in_geom, radius: in_radius, src: in_src, dst: in_dst};

  // Stall the whole pipe only when the last stage cannot drain
  assign adv    = !(vld[NST-1] && out_full);
  assign in_pop = adv && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Advance side data
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= in_side;
      for (int k = 1; k < NST; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // Square the offsets, then sum into the root operand
  assign dxx = in_dx * in_dx;
  assign dyy = in_dy * in_dy;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx2       <= dxx[SQ-1:0];
      dy2       <= dyy[SQ-1:0];
      rem_q[0]  <= NW'({({1'b0, dx2} + {1'b0, dy2}), 16'b0});
      root_q[0] <= '0;
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < R; k++) begin : g_root
    localparam int I = R - 1 - k;
    logic [NW:0] trial;
    logic        ge;
    assign trial = ((NW+1)'(root_q[k]) << (I + 1)) + ((NW+1)'(1) << (2 * I));
    assign ge    = ({1'b0, rem_q[k]} >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        root_q[k+1] <= ge ? (root_q[k] | (R'(1) << I)) : root_q[k];
      end
    end
    // Carry the remainder on to the next bit
    if (k < R - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q[k+1] <= ge ? rem_q[k] - trial[NW-1:0] : rem_q[k];
        end
      end
    end
  end

  // Edge distance and smoothstep classification
  assign e_w = $signed({{(EW-RW-8){1'b0}}, side[ST_E-1].radius, 8'b0}) -
               $signed({{(EW-R){1'b0}}, root_q[R]});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!side[ST_E-1].geom.in_rect) begin
        kind_e <= KIND_ZERO;
      end else if (!side[ST_E-1].geom.corner_hit || e_w >= EDGE_T) begin
        kind_e <= KIND_FULL;
      end else if (e_w <= -EDGE_T) begin
        kind_e <= KIND_ZERO;
      end else begin
        kind_e <= KIND_MID;
      end
      v_e <= VW'(e_w + EDGE_T);
    end
  end

  // Smoothstep polynomial v^2 * (9M - 2v)
  always_ff @(posedge clk) begin
    if (adv) begin
      kind_m1 <= kind_e;
      v2_m1   <= v_e * v_e;
      w_m1    <= NINE_M - {{(WW-VW-1){1'b0}}, v_e, 1'b0};
      kind_m2 <= kind_m1;
      p_m2    <= v2_m1 * w_m1;
    end
  end

  // Round and divide by 27*2^K via shift and reciprocal
  assign ysum  = {1'b0, p_m2} + ROUND_C;
  assign yprod = ysum[K-8 +: YW] * RECIP_27;

  always_ff @(posedge clk) begin
    if (adv) begin
      case (kind_m2)
        KIND_FULL: cov_d <= 9'd256;
        KIND_ZERO: cov_d <= '0;
        default:   cov_d <= yprod[20 +: 9];
      endcase
    end
  end

  // Scale source alpha by coverage
  assign aprod = side[ST_D].src[31:24] * cov_d;
  assign a_w   = aprod[15:8];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_q   <= a_w;
      cov_a <= cov_d;
      we_a  <= side[ST_D].geom.clip_ok && (cov_d != '0) && (a_w != '0);
    end
  end

  // Blend products per channel and saturate destination alpha
  assign da_sum = {1'b0, side[ST_A].dst[31:24]} + {1'b0, a_q};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        t_b[ch] <= side[ST_A].src[8*ch +: 8] * a_q +
                   side[ST_A].dst[8*ch +: 8] * (8'd255 - a_q);
      end
      da_b   <= da_sum[8] ? 8'd255 : da_sum[7:0];
      full_b <= (a_q == 8'd255);
      we_b   <= we_a;
      cov_b  <= cov_a;
    end
  end

  // Final pixel select
  always_comb begin
    if (!we_b) begin
      out_rgba = side[NST-1].dst;
    end else if (full_b) begin
      out_rgba = {8'hFF, side[NST-1].src[23:0]};
    end else begin
      out_rgba = {da_b, div255(t_b[2]), div255(t_b[1]), div255(t_b[0])};
    end
  end

  assign out_push = vld[NST-1] && !out_full;
  assign out_we   = we_b;
  assign out_cov  = cov_b;

  `RRCB_ASSERT_IMP(a_write_has_cov, out_push && out_we, out_cov != '0)
  `RRCB_ASSERT_IMP(a_drop_keeps_dst, out_push && !out_we, out_rgba == side[NST-1].dst)
  `RRCB_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld))

endmodule

/* sv/rounded_rect_coverage_blend.sv */
// ----------------------------------------------------------------------------
// rounded_rect_coverage_blend
// Rounded-rectangle corner coverage with smoothstep edge and alpha blend.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per pixel, in order.
// A front stage clips against the scissor box and screen and picks the
// corner; a two-entry queue separates it from a back pipeline of
// FRAC_BITS+26 stages, most of them the square root that settles one
// distance bit per stage, followed by the smoothstep and blend stages and a
// two-entry result queue. Throughput is one pixel per clock while pop
// keeps up. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module rounded_rect_coverage_blend import rrcb_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_BITS:0]        cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [COORD_BITS-1:0]      pixel_x,
  input  logic [COORD_BITS-1:0]      pixel_y,
  input  logic signed [COORD_BITS:0] rect_left,
  input  logic signed [COORD_BITS:0] rect_top,
  input  logic [COORD_BITS:0]        rect_width,
  input  logic [COORD_BITS:0]        rect_height,
  input  logic [FRAC_BITS+7:0]       radius_top_left,
  input  logic [FRAC_BITS+7:0]       radius_top_right,
  input  logic [FRAC_BITS+7:0]       radius_bottom_right,
  input  logic [FRAC_BITS+7:0]       radius_bottom_left,
  input  logic [31:0]                source_rgba,
  input  logic [31:0]                dest_rgba,
  output logic                       empty,
  input  logic                       pop,
  output logic                       write_enable,
  output logic [31:0]                result_rgba,
  output logic [8:0]                 coverage
);

  localparam int SD  = FRAC_BITS + 10;
  localparam int RW  = FRAC_BITS + 8;
  localparam int MQW = $bits(geom_t) + 2 * SD + RW + 64;
  localparam int OQW = 1 + 32 + 9;

  geom_t                 f_geom, b_geom;
  logic signed [SD-1:0]  f_dx, f_dy, b_dx, b_dy;
  logic [RW-1:0]         f_radius, b_radius;
  logic [31:0]           b_src, b_dst;
  logic [MQW-1:0]        mq_wdata, mq_rdata;
  logic                  mq_full, mq_empty, mq_pop;
  logic                  oq_full, oq_push, o_we;
  logic [31:0]           o_rgba;
  logic [8:0]            o_cov;

  assign cfg_ready = 1'b1;
  assign full      = mq_full;

  rrcb_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .pixel_x             (pixel_x),
    .pixel_y             (pixel_y),
    .rect_left           (rect_left),
    .rect_top            (rect_top),
    .rect_width          (rect_width),
    .rect_height         (rect_height),
    .radius_top_left     (radius_top_left),
    .radius_top_right    (radius_top_right),
    .radius_bottom_right (radius_bottom_right),
    .radius_bottom_left  (radius_bottom_left),
    .geom                (f_geom),
    .dx                  (f_dx),
    .dy                  (f_dy),
    .radius              (f_radius)
  );

  // Queue classified requests between front and back
  assign mq_wdata = {f_geom, f_dx, f_dy, f_radius, source_rgba, dest_rgba};
  assign {b_geom, b_dx, b_dy, b_radius, b_src, b_dst} = mq_rdata;

  rrcb_queue #(
    .WIDTH (MQW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .empty (mq_empty),
    .rdata (mq_rdata)
  );

  rrcb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mq_empty),
    .in_pop    (mq_pop),
    .in_geom   (b_geom),
    .in_dx     (b_dx),
    .in_dy     (b_dy),
    .in_radius (b_radius),
    .in_src    (b_src),
    .in_dst    (b_dst),
    .out_full  (oq_full),
    .out_push  (oq_push),
    .out_we    (o_we),
    .out_rgba  (o_rgba),
    .out_cov   (o_cov)
  );

  // Hold finished results until popped
  rrcb_queue #(
    .WIDTH (OQW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata ({o_we, o_rgba, o_cov}),
    .full  (oq_full),
    .pop   (pop),
    .empty (empty),
    .rdata ({write_enable, result_rgba, coverage})
  );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rounded-rect coverage blend unit. It replays a
// short table of directed pixel requests, then several phases of random
// requests under different scissor and screen settings and handshake idling.
// Every result is compared in request order against a hand-written value
// or an in-bench model of the corner coverage, clipping and blend.
// ----------------------------------------------------------------------------
module tb_top;
  import rrcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NUM_PHASES   = 10;
  localparam int  PHASE_REQS   = 115;
  localparam int  DRAIN_CYCLES = 40;
  localparam longint EDGE_T    = 3072;  // 0.75 px at 8+4 fraction bits
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic [11:0]        px, py;
    logic signed [12:0] rl, rt;
    logic [12:0]        rw, rh;
    logic [11:0]        rad_tl, rad_tr, rad_br, rad_bl;
    logic [31:0]        src, dst;
  } pixel_req_t;

  typedef struct {
    logic        we;
    logic [31:0] rgba;
    logic [8:0]  cov;
  } pixel_res_t;

  typedef struct {
    pixel_req_t req;
    bit         known;
    pixel_res_t res;
  } dir_row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [12:0] cfg_data;
  logic push, full, empty, pop;
  logic [11:0] pixel_x, pixel_y;
  logic signed [12:0] rect_left, rect_top;
  logic [12:0] rect_width, rect_height;
  logic [11:0] radius_top_left, radius_top_right, radius_bottom_right, radius_bottom_left;
  logic [31:0] source_rgba, dest_rgba;
  logic write_enable;
  logic [31:0] result_rgba;
  logic [8:0] coverage;

  // clip state mirrored from the register writes
  int unsigned clip_left, clip_top, clip_w, clip_h, scr_w, scr_h;
  int send_gap, recv_stall;
  int fails;
  pixel_res_t blend_fifo[$];
  dir_row_t dir_rows[$];

  rounded_rect_coverage_blend dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned corner_cov(pixel_req_t q);
    longint px, py, rx, ry, rw, rh, pxf, pyf, lf, tf, rf, bf, dx, dy, r, e;
    longint rtl, rtr, rbr, rbl;
    longint unsigned s, d, u, twot, num, den;
    px = q.px; py = q.py; rx = q.rl; ry = q.rt; rw = q.rw; rh = q.rh;
    rtl = q.rad_tl; rtr = q.rad_tr; rbr = q.rad_br; rbl = q.rad_bl;
    if (px < rx || px >= rx + rw || py < ry || py >= ry + rh) return 0;
    pxf = px * 16 + 8;
    pyf = py * 16 + 8;
    lf = rx * 16;
    tf = ry * 16;
    rf = (rx + rw) * 16;
    bf = (ry + rh) * 16;
    // first corner square holding the pixel wins: TL, TR, BL, BR
    if (px * 16 < lf + rtl && py * 16 < tf + rtl) begin
      r = rtl; dx = lf + r - pxf; dy = tf + r - pyf;
    end else if (px * 16 >= rf - rtr && py * 16 < tf + rtr) begin
      r = rtr; dx = pxf - (rf - r); dy = tf + r - pyf;
    end else if (px * 16 < lf + rbl && py * 16 >= bf - rbl) begin
      r = rbl; dx = lf + r - pxf; dy = pyf - (bf - r);
    end else if (px * 16 >= rf - rbr && py * 16 >= bf - rbr) begin
      r = rbr; dx = pxf - (rf - r); dy = pyf - (bf - r);
    end else begin
      return 256;
    end
    s = longint'(dx * dx) + longint'(dy * dy);
    d = int_sqrt(s << 16);
    e = r * 256 - longint'(d);
    if (e >= EDGE_T) return 256;
    if (e <= -EDGE_T) return 0;
    // smoothstep done exactly, rounded half up
    u = e + EDGE_T;
    twot = 2 * EDGE_T;
    num = u * u * (3 * twot - 2 * u) * 256;
    den = twot * twot * twot;
    return (num + den / 2) / den;
  endfunction

  function automatic pixel_res_t predict_blend(pixel_req_t q);
    pixel_res_t o;
    int unsigned cov, a, da, v, sc, dc;
    bit clip_ok;
    cov = corner_cov(q);
    clip_ok = q.px >= clip_left && q.px < clip_left + clip_w &&
              q.py >= clip_top && q.py < clip_top + clip_h &&
              q.px < scr_w && q.py < scr_h;
    a = (q.src[31:24] * cov) >> 8;
    o.we = 1'b0;
    o.rgba = q.dst;
    o.cov = cov[8:0];
    if (clip_ok && cov > 0 && a > 0) begin
      o.we = 1'b1;
      if (a == 255) begin
        o.rgba = {8'hFF, q.src[23:0]};
      end else begin
        for (int ch = 0; ch < 3; ch++) begin
          sc = q.src[8*ch +: 8];
          dc = q.dst[8*ch +: 8];
          v = (sc * a + dc * (255 - a)) / 255;
          o.rgba[8*ch +: 8] = v[7:0];
        end
        da = q.dst[31:24] + a;
        o.rgba[31:24] = (da > 255) ? 8'hFF : da[7:0];
      end
    end
    return o;
  endfunction

  function automatic pixel_req_t mk_req(int px, int py, int rl, int rt, int rw, int rh,
                                        int rtl, int rtr, int rbr, int rbl,
                                        logic [31:0] src, logic [31:0] dst);
    pixel_req_t q;
    q.px = 12'(px); q.py = 12'(py); q.rl = 13'(rl); q.rt = 13'(rt);
    q.rw = 13'(rw); q.rh = 13'(rh);
    q.rad_tl = 12'(rtl); q.rad_tr = 12'(rtr); q.rad_br = 12'(rbr); q.rad_bl = 12'(rbl);
    q.src = src; q.dst = dst;
    return q;
  endfunction

  function automatic void add_row(pixel_req_t q, bit known, logic we, logic [31:0] rgba,
                                  logic [8:0] cov);
    dir_row_t row;
    row.req = q;
    row.known = known;
    row.res.we = we;
    row.res.rgba = rgba;
    row.res.cov = cov;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Row checked against the predictor
  function automatic void add_chk(pixel_req_t q);
    add_row(q, 1'b0, 1'b0, 32'h0, 9'd0);
  endfunction

  function automatic logic [31:0] rand_rgba();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(3))
      0: c[31:24] = 8'hFF;
      1: c[31:24] = 8'h00;
      default: ;
    endcase
    return c;
  endfunction

  // Mostly small rectangles placed around the pixel so corners get exercised
  function automatic pixel_req_t rand_req();
    pixel_req_t q;
    int w, h;
    if ($urandom_range(99) < 15) begin
      q = mk_req($urandom, $urandom, $urandom, $urandom, $urandom_range(4096),
                 $urandom_range(4096), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      return q;
    end
    if ($urandom_range(99) < 70) begin
      q.px = 12'(clip_left + $urandom_range(((clip_w > 0) ? clip_w : 1) - 1));
      q.py = 12'(clip_top + $urandom_range(((clip_h > 0) ? clip_h : 1) - 1));
    end else begin
      q.px = 12'($urandom);
      q.py = 12'($urandom);
    end
    w = $urandom_range(1, 40);
    h = $urandom_range(1, 40);
    q.rw = 13'(w);
    q.rh = 13'(h);
    q.rl = $signed({1'b0, q.px}) - $signed(13'($urandom_range(w + 1)));
    q.rt = $signed({1'b0, q.py}) - $signed(13'($urandom_range(h + 1)));
    q.rad_tl = 12'($urandom_range(w * 16 + 40));
    q.rad_tr = 12'($urandom_range(w * 16 + 40));
    q.rad_br = 12'($urandom_range(h * 16 + 40));
    q.rad_bl = 12'($urandom_range(h * 16 + 40));
    if ($urandom_range(9) == 0) q.rad_tl = '0;
    q.src = rand_rgba();
    q.dst = $urandom;
    return q;
  endfunction

  // Write one register, then drop valid again
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCISSOR_LEFT:   clip_left = val[11:0];
      REG_SCISSOR_TOP:    clip_top = val[11:0];
      REG_SCISSOR_WIDTH:  clip_w = val;
      REG_SCISSOR_HEIGHT: clip_h = val;
      REG_SCREEN_WIDTH:   scr_w = val;
      REG_SCREEN_HEIGHT:  scr_h = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the request until accepted, then queue what it should produce
  task automatic send_req(pixel_req_t q, bit known, pixel_res_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_gap) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    pixel_x <= q.px; pixel_y <= q.py;
    rect_left <= q.rl; rect_top <= q.rt;
    rect_width <= q.rw; rect_height <= q.rh;
    radius_top_left <= q.rad_tl; radius_top_right <= q.rad_tr;
    radius_bottom_right <= q.rad_br; radius_bottom_left <= q.rad_bl;
    source_rgba <= q.src; dest_rgba <= q.dst;
    @(posedge clk);
    while (full) @(posedge clk);
    blend_fifo.insert(blend_fifo.size(), known ? res : predict_blend(q));
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    cfg_valid <= 1'b0;
    while (blend_fifo.size() != 0) @(posedge clk);
  endtask

  function automatic logic [12:0] rand_cfg(bit narrow);
    logic [12:0] v;
    v = narrow ? {1'($urandom), 12'($urandom_range(4095))} : 13'($urandom_range(4096));
    return v;
  endfunction

  // Drop the stall level into pop at each falling edge
  always @(negedge clk) begin
    pop <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    pixel_res_t e;
    if (!rst && pop && !empty) begin
      if (blend_fifo.size() == 0) begin
        $error("unexpected result: write_enable=%0b result_rgba=%h coverage=%0d",
               write_enable, result_rgba, coverage);
        fails++;
      end else begin
        e = blend_fifo.pop_front();
        if (write_enable !== e.we) begin
          $error("write_enable: expected %0b, got %0b", e.we, write_enable);
          fails++;
        end
        if (result_rgba !== e.rgba) begin
          $error("result_rgba: expected %h, got %h", e.rgba, result_rgba);
          fails++;
        end
        if (coverage !== e.cov) begin
          $error("coverage: expected %0d, got %0d", e.cov, coverage);
          fails++;
        end
      end
    end
  end

  initial begin
    pixel_res_t none;
    logic [12:0] lv, tv, wv, hv, swv, shv;
    fails = 0;
    send_gap = 0;
    recv_stall = 0;
    none = '{1'b0, 32'h0, 9'd0};
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = REG_SCISSOR_LEFT; cfg_data = '0;
    push = 1'b0;
    pixel_x = '0; pixel_y = '0; rect_left = '0; rect_top = '0;
    rect_width = '0; rect_height = '0;
    radius_top_left = '0; radius_top_right = '0;
    radius_bottom_right = '0; radius_bottom_left = '0;
    source_rgba = '0; dest_rgba = '0;
    clip_left = 0; clip_top = 0; clip_w = 4096; clip_h = 4096; scr_w = 4096; scr_h = 4096;

    // Directed rows, reset clip settings
    add_row(mk_req(10, 10, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFF112233, 32'h44556677),
            1, 1'b0, 32'h44556677, 9'd0);
    add_row(mk_req(5, 5, 0, 0, 20, 20, 0, 0, 0, 0, 32'hFF102030, 32'h0),
            1, 1'b1, 32'hFF102030, 9'd256);
    add_row(mk_req(5, 5, 0, 0, 20, 20, 0, 0, 0, 0, 32'h00AABBCC, 32'h12345678),
            1, 1'b0, 32'h12345678, 9'd256);
    add_row(mk_req(4095, 4095, -4096, -4096, 4096, 4096, 4095, 4095, 4095, 4095,
                   32'hFFFFFFFF, 32'hFFFFFFFF), 1, 1'b0, 32'hFFFFFFFF, 9'd0);
    add_row(mk_req(4095, 4095, 0, 0, 4096, 4096, 0, 0, 0, 0, 32'hFFFFFFFF, 32'h0),
            1, 1'b1, 32'hFFFFFFFF, 9'd256);
    add_chk(mk_req(0, 0, 0, 0, 4096, 4096, 4095, 4095, 4095, 4095, 32'hFF00FF00, 32'h0));
    add_chk(mk_req(0, 0, 0, 0, 16, 16, 64, 0, 0, 0, 32'hFF0000FF, 32'h80808080));
    add_chk(mk_req(15, 0, 0, 0, 16, 16, 0, 64, 0, 0, 32'hFF0000FF, 32'h80808080));
    add_chk(mk_req(0, 15, 0, 0, 16, 16, 0, 0, 0, 64, 32'hFF0000FF, 32'h80808080));
    add_chk(mk_req(15, 15, 0, 0, 16, 16, 0, 0, 64, 0, 32'hFF0000FF, 32'h80808080));
    add_chk(mk_req(1, 1, 0, 0, 16, 16, 64, 64, 64, 64, 32'hFF0000FF, 32'h0));
    add_chk(mk_req(5, 5, 0, 0, 20, 20, 0, 0, 0, 0, 32'h80C08040, 32'hC0102030));
    add_chk(mk_req(5, 5, 0, 0, 20, 20, 0, 0, 0, 0, 32'h80C08040, 32'hFF102030));
    add_chk(mk_req(0, 0, -5, -5, 10, 10, 4095, 0, 0, 0, 32'h7F123456, 32'h01FEDCBA));
    add_chk(mk_req(9, 9, 0, 0, 10, 10, 4095, 4095, 4095, 4095, 32'hFFFFFFFF, 32'h0));
    add_chk(mk_req(2, 9, 0, 0, 10, 10, 0, 0, 40, 40, 32'h40FFFFFF, 32'h0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // pick the clip setting of this phase, extremes first
      case (p)
        0: begin lv = 0; tv = 0; wv = 4096; hv = 4096; swv = 4096; shv = 4096; end
        1: begin lv = 13'h1FFF; tv = 13'h1FFF; wv = 4096; hv = 4096; swv = 4096; shv = 4096; end
        2: begin lv = 0; tv = 0; wv = 0; hv = 4096; swv = 4096; shv = 4096; end
        3: begin lv = 0; tv = 0; wv = 4096; hv = 0; swv = 0; shv = 0; end
        4: begin lv = 13'h1000; tv = 13'h1000; wv = 64; hv = 64; swv = 4096; shv = 4096; end
        default: begin
          lv = rand_cfg(1);
          tv = rand_cfg(1);
          wv = rand_cfg(0);
          hv = rand_cfg(0);
          swv = rand_cfg(0);
          shv = rand_cfg(0);
        end
      endcase
      if (p > 0) begin
        write_reg(REG_SCISSOR_LEFT, lv);
        write_reg(REG_SCISSOR_TOP, tv);
        write_reg(REG_SCISSOR_WIDTH, wv);
        write_reg(REG_SCISSOR_HEIGHT, hv);
        write_reg(REG_SCREEN_WIDTH, swv);
        write_reg(REG_SCREEN_HEIGHT, shv);
        if (p == 3 || p == 6) begin
          write_reg(REG_SPARE_A, 13'($urandom));
          write_reg(REG_SPARE_B, 13'($urandom));
        end
      end
      case (p % 4)
        0: begin send_gap = 0; recv_stall = 0; end
        1: begin send_gap = 45; recv_stall = 0; end
        2: begin send_gap = 0; recv_stall = 45; end
        default: begin send_gap = 15; recv_stall = 15; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) send_req(rand_req(), 0, none);
      drain();
      send_gap = 0;
      recv_stall = 0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && blend_fifo.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/rrcb_pkg.sv
sv/rrcb_queue.sv
sv/rrcb_front.sv
sv/rrcb_back.sv
sv/rounded_rect_coverage_blend.sv
test/tb_top.sv
